[sv/btf_pkg.sv]
// shared types and constants for the background tile fetcher
`default_nettype none

package btf_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_CONTROL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_X        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_Y        = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    // display control bit positions
    localparam int LCDC_BG_EN    = 0;
    localparam int LCDC_BG_MAP   = 3;
    localparam int LCDC_TILE_UNS = 4;
    localparam int LCDC_WIN_EN   = 5;
    localparam int LCDC_WIN_MAP  = 6;

    // commands from the controller to the datapath
    typedef struct packed {
        logic mem_we;    // write beat: store mem_byte
        logic rd_map;    // fetch beat: read the tile number
        logic rd_lo;     // read the low plane byte
        logic rd_hi;     // read the high plane byte
        logic cap_lo;    // low plane byte is on the read port
        logic load_out;  // high plane byte is on the read port, fill output
    } btf_cmd_t;

endpackage

`default_nettype wire

[sv/btf_ctrl.sv]
// fetch sequencer and output handshake control
`default_nettype none

module btf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          action,
    output logic               out_valid,
    input  wire logic          out_ready,
    output btf_pkg::btf_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free);
        accept   = in_valid && in_ready;

        cmd.mem_we   = accept && (action == btf_pkg::ACT_WRITE);
        cmd.rd_map   = accept && (action == btf_pkg::ACT_FETCH);
        cmd.rd_lo    = (state_reg == ST_LO);
        cmd.rd_hi    = (state_reg == ST_HI);
        cmd.cap_lo   = (state_reg == ST_HI);
        cmd.load_out = (state_reg == ST_DONE) && out_free;

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.rd_map)
                    state_next = ST_LO;
            end
            ST_LO:   state_next = ST_HI;
            ST_HI:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (cmd.rd_map)
                    state_next = ST_LO;
                else if (cmd.load_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[sv/btf_datapath.sv]
// video memory, config registers, address generation and pixel output
`default_nettype none

module btf_datapath #(
    parameter int VIDEO_MEM_BYTES = 8192,
    parameter int AW              = $clog2(VIDEO_MEM_BYTES)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire btf_pkg::btf_cmd_t               cmd,
    input  wire logic                            cfg_valid,
    input  wire logic [btf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [btf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [AW-1:0]                   mem_offset,
    input  wire logic [7:0]                      mem_byte,
    input  wire logic [4:0]                      tile_column,
    input  wire logic [7:0]                      line_number,
    input  wire logic                            window_fetch,
    input  wire logic [7:0]                      window_line,
    output logic [15:0]                          pixel_colors
);

    logic [7:0]    vram [VIDEO_MEM_BYTES];
    logic [7:0]    rdata_reg;

    logic [7:0]    lcdc_reg;
    logic [7:0]    scx_reg;
    logic [7:0]    scy_reg;

    logic [2:0]    fine_row_reg;
    logic          bg_en_reg;
    logic [AW-1:0] tile_addr_reg;
    logic [7:0]    lo_reg;
    logic [15:0]   pix_reg;

    logic          use_win;
    logic          map_sel;
    logic [7:0]    row;
    logic [4:0]    col;
    logic [12:0]   map_addr;
    logic [12:0]   tile_addr;
    logic [AW-1:0] mem_addr;
    logic          mem_re;
    logic [15:0]   pix_next;

    always_comb
    begin
        use_win = window_fetch && lcdc_reg[btf_pkg::LCDC_WIN_EN];
        map_sel = use_win ? lcdc_reg[btf_pkg::LCDC_WIN_MAP] : lcdc_reg[btf_pkg::LCDC_BG_MAP];
        row     = use_win ? window_line : line_number + scy_reg;
        col     = use_win ? tile_column : tile_column + scx_reg[7:3];
        // maps live at 0x1800 and 0x1c00 from the memory base
        map_addr = {2'b11, map_sel, row[7:3], col};

        // signed mode: base 0x1000 plus the sign-extended tile number times 16
        tile_addr = {!lcdc_reg[btf_pkg::LCDC_TILE_UNS] && !rdata_reg[7],
                     rdata_reg, fine_row_reg, 1'b0};

        mem_re = cmd.rd_map || cmd.rd_lo || cmd.rd_hi;
        if (cmd.mem_we)
            mem_addr = mem_offset;
        else if (cmd.rd_map)
            mem_addr = AW'(map_addr);
        else if (cmd.rd_lo)
            mem_addr = AW'(tile_addr);
        else
            mem_addr = {tile_addr_reg[AW-1:1], 1'b1};

        // high plane gives the upper bit of each index
        for (int p = 0; p < 8; p++)
        begin
            pix_next[15 - 2*p] = rdata_reg[7 - p];
            pix_next[14 - 2*p] = lo_reg[7 - p];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            vram[mem_addr] <= mem_byte;
        if (mem_re)
            rdata_reg <= vram[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcdc_reg <= '0;
            scx_reg  <= '0;
            scy_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                btf_pkg::CFG_DISPLAY_CONTROL: lcdc_reg <= cfg_data;
                btf_pkg::CFG_SCROLL_X:        scx_reg  <= cfg_data;
                btf_pkg::CFG_SCROLL_Y:        scy_reg  <= cfg_data;
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_map)
        begin
            fine_row_reg <= row[2:0];
            bg_en_reg    <= lcdc_reg[btf_pkg::LCDC_BG_EN];
        end
        if (cmd.rd_lo)
            tile_addr_reg <= AW'(tile_addr);
        if (cmd.cap_lo)
            lo_reg <= rdata_reg;
        if (cmd.load_out)
            pix_reg <= bg_en_reg ? pix_next : '0;
    end

    assign pixel_colors = pix_reg;

endmodule

`default_nettype wire

[sv/background_tile_fetcher.sv]
// top level of the background tile fetcher
// a fetch beat makes three dependent reads of the single-port vram: map, low and high plane
// then loads its pixels once the output is free; no new beat is taken during the plane reads
// write beats produce no output beat
// reset: rst_n async active low clears the sequencer, output valid and config registers
// video memory contents are not cleared by reset and hold garbage until written
`default_nettype none

module background_tile_fetcher #(
    parameter int VIDEO_MEM_BYTES = 8192
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,

    // config write channel, always ready
    input  wire logic                                       cfg_valid,
    output logic                                            cfg_ready,
    input  wire logic [btf_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  wire logic [btf_pkg::CFG_DATA_W-1:0]             cfg_data,

    // input beats: vram writes and tile row fetches
    input  wire logic                                       in_valid,
    output logic                                            in_ready,
    input  wire logic                                       action,
    input  wire logic [$clog2(VIDEO_MEM_BYTES)-1:0]         mem_offset,
    input  wire logic [7:0]                                 mem_byte,
    input  wire logic [4:0]                                 tile_column,
    input  wire logic [7:0]                                 line_number,
    input  wire logic                                       window_fetch,
    input  wire logic [7:0]                                 window_line,

    // output beats: one row of eight 2-bit pixels per fetch
    output logic                                            out_valid,
    input  wire logic                                       out_ready,
    output logic [15:0]                                     pixel_colors
);

    btf_pkg::btf_cmd_t cmd;

    // the user must change config registers only while the block is idle; the block does not enforce it
    assign cfg_ready = 1'b1;

    // sequencer: map read, low plane read, high plane read, then output load;
    // the next beat is taken in the same cycle the output register is loaded
    btf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // datapath holds the vram, the scroll and control registers and the pixel register
    btf_datapath #(
        .VIDEO_MEM_BYTES (VIDEO_MEM_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mem_offset   (mem_offset),
        .mem_byte     (mem_byte),
        .tile_column  (tile_column),
        .line_number  (line_number),
        .window_fetch (window_fetch),
        .window_line  (window_line),
        .pixel_colors (pixel_colors)
    );

endmodule

`default_nettype wire

[sv/btf_checker.sv]
// port level assertions for the background tile fetcher and their bind
`default_nettype none

module btf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        action,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] pixel_colors
);

    // a stalled output beat holds its pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_colors))
    else $error("output beat changed while stalled");

    // a write beat never blocks the next beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action == btf_pkg::ACT_WRITE) |=> in_ready)
    else $error("ready dropped after a write beat");

    // a fetch keeps the memory port busy for the two plane reads
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action == btf_pkg::ACT_FETCH) |=> !in_ready ##1 !in_ready)
    else $error("beat taken during plane reads");

    // a fresh output beat comes from an accepted fetch beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && (action == btf_pkg::ACT_FETCH), 4))
    else $error("output beat without a matching fetch");

endmodule

bind background_tile_fetcher btf_checker u_btf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_colors (pixel_colors)
);

`default_nettype wire
